[rtl/tss_pkg.sv]
// Shared types, widths and helpers for the Taylor series sine block.
// No dependencies; used by every other file in rtl/.
`timescale 1ns / 1ps

package tss_pkg;

  localparam int MAX_TERMS_DEF = 10;
  localparam int FRAC_BITS_DEF = 24;

  localparam int ANGLE_W  = 32;
  localparam int COUNT_W  = 4;
  localparam int X2_W     = 31;
  localparam int D_W      = 10;  // (2k)(2k+1) for k up to 14
  localparam int SUM_W    = 36;  // 15 terms of up to 2^31 each, plus sign
  localparam int PROD_W   = 63;  // 2^31 * 2^31 fits in 63 bits
  localparam int DIV_BITS = 8;   // quotient bits retired per divider cycle

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic [COUNT_W-1:0]        term_count;
  } in_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] sine_value;
    logic                      overflow;
  } out_t;

  typedef struct packed {
    logic               load;
    logic               square;
    logic               x2_load;
    logic               first_term;
    logic               mul_term;
    logic               div_load;
    logic               div_step;
    logic               update;
    logic               finish;
    logic [COUNT_W-1:0] k;
  } cmd_t;

  // divider cycles needed to cover the shifted product
  function automatic int div_steps(input int frac_bits);
    return (PROD_W - frac_bits + DIV_BITS - 1) / DIV_BITS;
  endfunction

  // (2k)(2k+1), the divisor of term k
  function automatic logic [D_W-1:0] term_divisor(input logic [COUNT_W-1:0] k);
    return D_W'({k, 1'b0}) * D_W'({k, 1'b1});
  endfunction

endpackage

[rtl/tss_ctrl.sv]
// Sequencer for the Taylor series sine block: term and divider counters.
// Depends on tss_pkg; drives the command struct of tss_datapath.
`timescale 1ns / 1ps

module tss_ctrl #(
  parameter int MAX_TERMS = tss_pkg::MAX_TERMS_DEF,
  parameter int FRAC_BITS = tss_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tss_pkg::COUNT_W-1:0] term_count,
  output logic                        busy,
  output tss_pkg::cmd_t               cmd
);

  localparam int DIV_STEPS = tss_pkg::div_steps(FRAC_BITS);
  localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SQUARE = 8'b0000_0010,
    S_X2     = 8'b0000_0100,
    S_MUL    = 8'b0000_1000,
    S_DIVSET = 8'b0001_0000,
    S_DIV    = 8'b0010_0000,
    S_UPDATE = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_t;

  state_t                      state, state_next;
  logic [tss_pkg::COUNT_W-1:0] n;
  logic [tss_pkg::COUNT_W-1:0] k;
  logic [STEP_W-1:0]           step;
  logic [tss_pkg::COUNT_W-1:0] n_clamped;

  assign n_clamped = (term_count > tss_pkg::COUNT_W'(MAX_TERMS)) ?
                     tss_pkg::COUNT_W'(MAX_TERMS) : term_count;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.k      = k;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_SQUARE;
        end
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_next = S_X2;
      end
      S_X2: begin
        cmd.x2_load    = 1'b1;
        cmd.first_term = (n != '0);
        state_next     = (n > tss_pkg::COUNT_W'(1)) ? S_MUL : S_FINISH;
      end
      S_MUL: begin
        cmd.mul_term = 1'b1;
        state_next   = S_DIVSET;
      end
      S_DIVSET: begin
        cmd.div_load = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = (({1'b0, k} + 5'd1) < {1'b0, n}) ? S_MUL : S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n <= n_clamped;
    end
    if (cmd.x2_load) begin
      k <= tss_pkg::COUNT_W'(1);
    end else if (cmd.update) begin
      k <= k + tss_pkg::COUNT_W'(1);
    end
    if (cmd.div_load) begin
      step <= '0;
    end else if (cmd.div_step) begin
      step <= step + STEP_W'(1);
    end
  end

endmodule

[rtl/tss_datapath.sv]
// Datapath for the Taylor series sine block: shared multiplier, radix-256
// restoring divider, term magnitude/sign, running sum and output register.
// Depends on tss_pkg; sequenced by tss_ctrl.
`timescale 1ns / 1ps

module tss_datapath #(
  parameter int FRAC_BITS = tss_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  tss_pkg::cmd_t cmd,
  input  tss_pkg::in_t  operand,
  output tss_pkg::out_t result,
  output logic          done
);

  localparam int DIV_STEPS = tss_pkg::div_steps(FRAC_BITS);
  localparam int NUM_W     = DIV_STEPS * tss_pkg::DIV_BITS;
  localparam int PROD_W    = tss_pkg::PROD_W;
  localparam int SUM_W     = tss_pkg::SUM_W;
  localparam int D_W       = tss_pkg::D_W;
  localparam int DB        = tss_pkg::DIV_BITS;

  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(-64'sd2147483648);
  localparam logic [NUM_W-1:0]        LIM_POS = NUM_W'(33'h0_7FFF_FFFF);
  localparam logic [NUM_W-1:0]        LIM_NEG = NUM_W'(33'h0_8000_0000);

  logic                        tneg;
  logic [31:0]                 tmag;
  logic [tss_pkg::X2_W-1:0]    x2;
  logic                        sq_sat;
  logic                        ovf;
  logic [PROD_W-1:0]           prod;
  logic [NUM_W-1:0]            num;
  logic [D_W-1:0]              rem;
  logic [D_W-1:0]              dvsr;
  logic signed [SUM_W-1:0]     sum;

  logic [31:0]                 angle_u;
  logic [31:0]                 mul_b;
  logic [63:0]                 mul_full;
  logic [PROD_W-1:0]           shifted;
  logic [D_W-1:0]              rem_next;
  logic [DB-1:0]               qbits;
  logic                        tneg_next;
  logic [NUM_W-1:0]            qlim;
  logic [NUM_W-1:0]            qclamp;
  logic                        qsat;
  logic signed [SUM_W-1:0]     tmag_ext;
  logic signed [SUM_W-1:0]     qclamp_ext;

  assign angle_u  = operand.angle;
  assign mul_b    = cmd.square ? tmag : {1'b0, x2};
  assign mul_full = 64'(tmag) * 64'(mul_b);
  assign shifted  = prod >> FRAC_BITS;
  assign tmag_ext = $signed({{(SUM_W-32){1'b0}}, tmag});

  // one quotient digit of DB bits; partial remainder stays below the divisor
  always_comb begin
    logic [D_W:0] t;
    rem_next = rem;
    qbits    = '0;
    for (int i = 0; i < DB; i++) begin
      t = {rem_next, num[NUM_W-1-i]};
      if (t >= {1'b0, dvsr}) begin
        t           = t - {1'b0, dvsr};
        qbits[DB-1-i] = 1'b1;
      end
      rem_next = t[D_W-1:0];
    end
  end

  // new term: sign flips, a zero term is positive, clamp to the 32-bit range
  assign tneg_next  = (num != '0) && !tneg;
  assign qlim       = tneg_next ? LIM_NEG : LIM_POS;
  assign qsat       = (num > qlim);
  assign qclamp     = qsat ? qlim : num;
  assign qclamp_ext = $signed({{(SUM_W-32){1'b0}}, qclamp[31:0]});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tneg <= operand.angle[31];
      tmag <= operand.angle[31] ? (~angle_u + 32'd1) : angle_u;
      ovf  <= 1'b0;
    end
    if (cmd.square || cmd.mul_term) begin
      prod <= mul_full[PROD_W-1:0];
    end
    if (cmd.x2_load) begin
      if (shifted > PROD_W'(31'h7FFF_FFFF)) begin
        x2     <= '1;
        sq_sat <= 1'b1;
      end else begin
        x2     <= shifted[tss_pkg::X2_W-1:0];
        sq_sat <= 1'b0;
      end
      if (cmd.first_term) begin
        sum <= tneg ? -tmag_ext : tmag_ext;
      end else begin
        sum <= '0;
      end
    end
    if (cmd.div_load) begin
      num  <= NUM_W'(shifted);
      rem  <= '0;
      dvsr <= tss_pkg::term_divisor(cmd.k);
      if (sq_sat) begin
        ovf <= 1'b1;
      end
    end
    if (cmd.div_step) begin
      num <= {num[NUM_W-DB-1:0], qbits};
      rem <= rem_next;
    end
    if (cmd.update) begin
      tneg <= tneg_next;
      tmag <= qclamp[31:0];
      sum  <= tneg_next ? (sum - qclamp_ext) : (sum + qclamp_ext);
      if (qsat) begin
        ovf <= 1'b1;
      end
    end
    if (cmd.finish) begin
      if (sum > SUM_MAX) begin
        result.sine_value <= 32'sh7FFF_FFFF;
        result.overflow   <= 1'b1;
      end else if (sum < SUM_MIN) begin
        result.sine_value <= 32'sh8000_0000;
        result.overflow   <= 1'b1;
      end else begin
        result.sine_value <= sum[31:0];
        result.overflow   <= ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

endmodule

[rtl/taylor_sine_series_top.sv]
// Taylor series sine, signed fixed point: result strobed on done one beat per start.
// Sequence: load, square the angle, then per further term a multiply, divider load,
// divider steps and update, then finish; angle and result are Q7.24 by default.
// One item at a time; busy is high until done, a new start is taken in the done cycle.
// Each term after the first uses the shared multiplier and the 8-bit-per-cycle divider.
// Synchronous active-high rst returns to idle with done low; no clearing pass.
`timescale 1ns / 1ps

module taylor_sine_series_top #(
  parameter int MAX_TERMS = tss_pkg::MAX_TERMS_DEF,
  parameter int FRAC_BITS = tss_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  tss_pkg::in_t  operand,
  output logic          busy,
  output logic          done,
  output tss_pkg::out_t result
);

  tss_pkg::cmd_t cmd;

  tss_ctrl #(
    .MAX_TERMS (MAX_TERMS),
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .term_count (operand.term_count),
    .busy       (busy),
    .cmd        (cmd)
  );

  tss_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .operand (operand),
    .result  (result),
    .done    (done)
  );

endmodule

[rtl/tss_checker.sv]
// Port-level checks for taylor_sine_series_top, attached by bind.
// Depends on tss_pkg and taylor_sine_series_top.
`timescale 1ns / 1ps

module tss_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input tss_pkg::in_t  operand,
  input logic          busy,
  input logic          done,
  input tss_pkg::out_t result
);

  // reset leaves the block idle with no result beat
  a_reset_idle: assert property (@(posedge clk) rst |=> (!busy && !done))
    else $error("block not idle after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  // a result beat always closes a busy period
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(busy)))
    else $error("done without a preceding busy period");

  a_busy_ends_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result beat");

  // zero terms: zero result, no overflow, fixed latency
  a_zero_terms: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (operand.term_count == 4'd0)) |->
      ##4 (done && (result.sine_value == 32'sd0) && !result.overflow))
    else $error("zero-term item gave a wrong result");

endmodule

bind taylor_sine_series_top tss_checker u_tss_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .operand (operand),
  .busy    (busy),
  .done    (done),
  .result  (result)
);
